// ===== hdl/incremental_pd_i_position_regulator_defines.svh =====
// Assertion macros for the position regulator.
`ifndef INCREMENTAL_PD_I_POSITION_REGULATOR_DEFINES_SVH
`define INCREMENTAL_PD_I_POSITION_REGULATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, masked while reset is asserted
`define IPDR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Clocked check that also runs while reset is asserted
`define IPDR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define IPDR_ASSERT(lbl, prop, msg)
`define IPDR_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ===== hdl/ipdr_pkg.sv =====
// Types, constants and step decode shared by the position regulator.
package ipdr_pkg;

  // Default fixed-point shape
  localparam int FracBitsDef = 16;
  localparam int IncBitsDef  = 16;
  localparam int RstFrac     = 16;

  // Fixed field and state widths
  localparam int IntegW    = 48;
  localparam int ChunkW    = IntegW / 2;
  localparam int DriveW    = 16;
  localparam int MaxDriveW = 15;
  localparam int DriveIntW = 17;
  localparam int CfgIdxW   = 3;

  // Multiply sequence: two chunks for each of six terms
  localparam int StepW    = 4;
  localparam int NumSteps = 12;
  localparam int StepsE   = 4;

  // Register reset values, Q1.16 (max drive in whole drive units)
  localparam int unsigned ErrGainNewRst = 66060;
  localparam int unsigned ErrGainOldRst = 65012;
  localparam int unsigned PoleWeightRst = 17988;
  localparam int unsigned GainNowRst    = 51651;
  localparam int unsigned GainPrevRst   = 48123;
  localparam int unsigned MaxDriveRst   = 1000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ERR_GAIN_NEW = 3'd0,
    CFG_ERR_GAIN_OLD = 3'd1,
    CFG_POLE_WEIGHT  = 3'd2,
    CFG_GAIN_NOW     = 3'd3,
    CFG_GAIN_PREV    = 3'd4,
    CFG_MAX_DRIVE    = 3'd5
  } cfg_reg_e;

  // Operand/coefficient pair used by one multiply step
  typedef enum logic [2:0] {
    TERM_D_NEW,
    TERM_D_OLD,
    TERM_U1,
    TERM_U2,
    TERM_E,
    TERM_E1
  } term_e;

  typedef struct packed {
    term_e term;
    logic  hi;
    logic  neg;
  } step_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC_E,
    ST_DRAIN_E,
    ST_SAT_E,
    ST_MAC_U,
    ST_DRAIN_U,
    ST_CLAMP
  } state_e;

  // Rescale a Q1.16 reset constant to another fraction width
  function automatic int unsigned scale_coef(int unsigned base, int frac);
    if (frac >= RstFrac) begin
      return base << (frac - RstFrac);
    end else begin
      return base >> (RstFrac - frac);
    end
  endfunction

  // Step number: bit 0 picks the upper chunk, bit 1 subtracts
  function automatic step_t step_decode(logic [StepW-1:0] stp);
    step_t s;
    s.hi  = stp[0];
    s.neg = stp[1];
    unique case (stp[StepW-1:1])
      3'd0:    s.term = TERM_D_NEW;
      3'd1:    s.term = TERM_D_OLD;
      3'd2:    s.term = TERM_U1;
      3'd3:    s.term = TERM_U2;
      3'd4:    s.term = TERM_E;
      default: s.term = TERM_E1;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/incremental_pd_i_position_regulator.sv =====
// Incremental PD+I position regulator around one shared multiplier.
// Each input beat (setpoint and measured increment) runs through a fixed
// sequence of 12 multiplies on one signed (FRAC_BITS+3) x 25 multiplier,
// two chunks per term, four for the integral increment and eight for the
// drive, plus saturate and clamp steps. The input stalls from acceptance
// until the sequence is back in idle, so no new beat is taken before the
// last one has passed its clamp step, which waits while the output register
// still holds an unaccepted result. No other multiplier is used. A finished
// result sits in an output register; the next item may start while it
// waits. Configuration writes are always ready and take effect at once.
`include "incremental_pd_i_position_regulator_defines.svh"
module incremental_pd_i_position_regulator
  import ipdr_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef,
  parameter int INC_BITS  = IncBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [INC_BITS-1:0] setpoint_increment_i,
  input  logic signed [INC_BITS-1:0] measured_increment_i,
  input  logic                       clear_history_i,
  // Output channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [DriveW-1:0]   drive_value_o,
  // Configuration write channel
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [((FRAC_BITS + 1 > MaxDriveW) ? FRAC_BITS + 1 : MaxDriveW) - 1:0] cfg_wdata_i
);

  localparam int CoefW = FRAC_BITS + 1;
  localparam int OneAW = FRAC_BITS + 2;
  localparam int MulAW = FRAC_BITS + 3;
  localparam int MulBW = ChunkW + 1;
  localparam int ProdW = MulAW + MulBW;
  localparam int DiffW = INC_BITS + 1;
  localparam int HistW = FRAC_BITS + DriveIntW;
  localparam int AccW  = IntegW + FRAC_BITS + 5;

  localparam logic [CoefW-1:0] ErrGainNewInit = CoefW'(scale_coef(ErrGainNewRst, FRAC_BITS));
  localparam logic [CoefW-1:0] ErrGainOldInit = CoefW'(scale_coef(ErrGainOldRst, FRAC_BITS));
  localparam logic [CoefW-1:0] PoleWeightInit = CoefW'(scale_coef(PoleWeightRst, FRAC_BITS));
  localparam logic [CoefW-1:0] GainNowInit    = CoefW'(scale_coef(GainNowRst, FRAC_BITS));
  localparam logic [CoefW-1:0] GainPrevInit   = CoefW'(scale_coef(GainPrevRst, FRAC_BITS));

  localparam logic signed [AccW-1:0] EMax =
    {{(AccW - IntegW + 1){1'b0}}, {(IntegW - 1){1'b1}}};
  localparam logic signed [AccW-1:0] EMin =
    {{(AccW - IntegW + 1){1'b1}}, {(IntegW - 1){1'b0}}};
  localparam logic [OneAW-1:0] OneQ     = OneAW'(1) << FRAC_BITS;
  localparam logic [HistW-1:0] FracMask = (HistW'(1) << FRAC_BITS) - HistW'(1);

  // Configuration registers
  logic [CoefW-1:0]     err_gain_new_q, err_gain_old_q, pole_weight_q;
  logic [CoefW-1:0]     gain_now_q, gain_prev_q;
  logic [MaxDriveW-1:0] max_drive_q;

  // Sequencer
  state_e           state_q, state_d;
  logic [StepW-1:0] stp_q;
  logic             accept, issue, sat_en, clamp_en, out_free;

  // Working and history registers
  logic signed [INC_BITS-1:0] r_q, y_q, r1_q, y1_q;
  logic signed [IntegW-1:0]   e_q, e1_q;
  logic signed [HistW-1:0]    u1_q, u2_q;
  logic signed [AccW-1:0]     acc_q;
  logic signed [ProdW-1:0]    prod_q;
  logic                       prod_hi_q, prod_neg_q, prod_vld_q;
  logic signed [DriveW-1:0]   drive_q;
  logic                       out_vld_q;

  // Datapath nets
  step_t                     cur;
  logic signed [DiffW-1:0]   d_new, d_old;
  logic signed [IntegW-1:0]  opnd;
  logic [OneAW-1:0]          coef, one_a;
  logic signed [MulAW-1:0]   mul_a;
  logic signed [MulBW-1:0]   mul_b;
  logic signed [ProdW-1:0]   prod;
  logic signed [AccW-1:0]    term_ext, term_sh, acc_sum;
  logic signed [IntegW-1:0]  e_sat;
  logic signed [AccW-1:0]    u_sh, lim, u_clamp;
  logic signed [HistW-1:0]   u_new, u_rnd, u_int;

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign out_valid_o   = out_vld_q;
  assign drive_value_o = drive_q;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_gain_new_q <= ErrGainNewInit;
      err_gain_old_q <= ErrGainOldInit;
      pole_weight_q  <= PoleWeightInit;
      gain_now_q     <= GainNowInit;
      gain_prev_q    <= GainPrevInit;
      max_drive_q    <= MaxDriveW'(MaxDriveRst);
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_ERR_GAIN_NEW: err_gain_new_q <= cfg_wdata_i[CoefW-1:0];
        CFG_ERR_GAIN_OLD: err_gain_old_q <= cfg_wdata_i[CoefW-1:0];
        CFG_POLE_WEIGHT:  pole_weight_q  <= cfg_wdata_i[CoefW-1:0];
        CFG_GAIN_NOW:     gain_now_q     <= cfg_wdata_i[CoefW-1:0];
        CFG_GAIN_PREV:    gain_prev_q    <= cfg_wdata_i[CoefW-1:0];
        CFG_MAX_DRIVE:    max_drive_q    <= cfg_wdata_i[MaxDriveW-1:0];
        default: ;
      endcase
    end
  end

  // Hold the sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and step strobes
  always_comb begin
    state_d  = state_q;
    accept   = 1'b0;
    issue    = 1'b0;
    sat_en   = 1'b0;
    clamp_en = 1'b0;
    out_free = !out_vld_q || !out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          accept  = 1'b1;
          state_d = ST_MAC_E;
        end
      end
      ST_MAC_E: begin
        issue = 1'b1;
        if (stp_q == StepW'(StepsE - 1)) begin
          state_d = ST_DRAIN_E;
        end
      end
      ST_DRAIN_E: state_d = ST_SAT_E;
      ST_SAT_E: begin
        sat_en  = 1'b1;
        state_d = ST_MAC_U;
      end
      ST_MAC_U: begin
        issue = 1'b1;
        if (stp_q == StepW'(NumSteps - 1)) begin
          state_d = ST_DRAIN_U;
        end
      end
      ST_DRAIN_U: state_d = ST_CLAMP;
      ST_CLAMP: begin
        if (out_free) begin
          clamp_en = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Operand and coefficient selection for the current step
  always_comb begin
    cur   = step_decode(stp_q);
    d_new = DiffW'(r_q) - DiffW'(y_q);
    d_old = DiffW'(r1_q) - DiffW'(y1_q);
    one_a = OneAW'(pole_weight_q) + OneQ;
    unique case (cur.term)
      TERM_D_NEW: begin
        opnd = IntegW'(d_new);
        coef = OneAW'(err_gain_new_q);
      end
      TERM_D_OLD: begin
        opnd = IntegW'(d_old);
        coef = OneAW'(err_gain_old_q);
      end
      TERM_U1: begin
        opnd = IntegW'(u1_q);
        coef = one_a;
      end
      TERM_U2: begin
        opnd = IntegW'(u2_q);
        coef = OneAW'(pole_weight_q);
      end
      TERM_E: begin
        opnd = e_q;
        coef = OneAW'(gain_now_q);
      end
      default: begin
        opnd = e1_q;
        coef = OneAW'(gain_prev_q);
      end
    endcase
    mul_a = $signed({1'b0, coef});
    mul_b = cur.hi ? MulBW'($signed(opnd[IntegW-1:ChunkW]))
                   : $signed({1'b0, opnd[ChunkW-1:0]});
    prod  = mul_a * mul_b;
  end

  // Accumulate the registered partial product
  always_comb begin
    term_ext = AccW'(prod_q);
    term_sh  = prod_hi_q ? (term_ext <<< ChunkW) : term_ext;
    acc_sum  = prod_neg_q ? (acc_q - term_sh) : (acc_q + term_sh);
  end

  // Saturate the integral increment, floor and clamp the drive, round it toward zero
  always_comb begin
    if (acc_q > EMax) begin
      e_sat = EMax[IntegW-1:0];
    end else if (acc_q < EMin) begin
      e_sat = EMin[IntegW-1:0];
    end else begin
      e_sat = acc_q[IntegW-1:0];
    end
    u_sh = acc_q >>> FRAC_BITS;
    lim  = AccW'(max_drive_q) << FRAC_BITS;
    if (u_sh > lim) begin
      u_clamp = lim;
    end else if (u_sh < -lim) begin
      u_clamp = -lim;
    end else begin
      u_clamp = u_sh;
    end
    u_new = u_clamp[HistW-1:0];
    u_rnd = u_new + (u_new[HistW-1] ? FracMask : HistW'(0));
    u_int = u_rnd >>> FRAC_BITS;
  end

  // Step counter and product pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stp_q      <= '0;
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= issue;
      if (accept) begin
        stp_q <= '0;
      end else if (issue) begin
        stp_q <= stp_q + StepW'(1);
      end
    end
  end

  // Product register
  always_ff @(posedge clk_i) begin
    if (issue) begin
      prod_q     <= prod;
      prod_hi_q  <= cur.hi;
      prod_neg_q <= cur.neg;
    end
  end

  // Capture the beat, accumulate, saturate
  always_ff @(posedge clk_i) begin
    if (accept) begin
      r_q   <= setpoint_increment_i;
      y_q   <= measured_increment_i;
      acc_q <= clear_history_i ? '0 : AccW'(e1_q);
    end else if (prod_vld_q) begin
      acc_q <= acc_sum;
    end else if (sat_en) begin
      e_q   <= e_sat;
      acc_q <= '0;
    end
  end

  // History: clear on request, shift once the drive is final
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q <= '0;
      y1_q <= '0;
      e1_q <= '0;
      u1_q <= '0;
      u2_q <= '0;
    end else if (accept && clear_history_i) begin
      r1_q <= '0;
      y1_q <= '0;
      e1_q <= '0;
      u1_q <= '0;
      u2_q <= '0;
    end else if (clamp_en) begin
      r1_q <= r_q;
      y1_q <= y_q;
      e1_q <= e_q;
      u2_q <= u1_q;
      u1_q <= u_new;
    end
  end

  // Output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (clamp_en) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clamp_en) begin
      drive_q <= u_int[DriveW-1:0];
    end
  end

  `IPDR_ASSERT(a_out_from_clamp, $rose(out_vld_q) |-> $past(state_q == ST_CLAMP), "result without clamp step")
  `IPDR_ASSERT(a_drive_in_limit, out_vld_q |-> (AccW'(u1_q) <= lim && AccW'(u1_q) >= -lim), "drive beyond limit")
  `IPDR_ASSERT(a_idle_drained, (state_q == ST_IDLE) |-> !prod_vld_q, "product pending while idle")
  `IPDR_ASSERT_RST(a_reset_quiet, !rst_ni |-> (!out_vld_q && !prod_vld_q && !in_stall_o), "activity in reset")

endmodule

// ===== bench/incremental_pd_i_position_regulator_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the incremental PD+I position regulator.
module incremental_pd_i_position_regulator_test;
  import ipdr_pkg::*;

  localparam int IncW       = IncBitsDef;
  localparam int CfgDataW   = (FracBitsDef + 1 > MaxDriveW) ? FracBitsDef + 1 : MaxDriveW;
  localparam int CoefMax    = (1 << (FracBitsDef + 1)) - 1;
  localparam int DriveCap   = (1 << MaxDriveW) - 1;
  localparam int SettleCyc  = 24;
  localparam int WindupLen  = 50;
  localparam longint CycleLimit = 200000;
  // Register indexes past the end of the map
  localparam logic [CfgIdxW-1:0] CfgIdxSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareB = 3'd7;

  // Drive predictor and queue of drive values still owed by the block
  class drive_tracker;
    longint gain_new, gain_old, pole, gain_b0, gain_b1, limit;
    longint sp_last, ms_last, integ_last, drive_last, drive_older;
    longint hi_sum, lo_sum;
    logic signed [DriveW-1:0] drive_due[$];
    int mismatches;
    int checked;

    function new();
      gain_new = ErrGainNewRst;
      gain_old = ErrGainOldRst;
      pole     = PoleWeightRst;
      gain_b0  = GainNowRst;
      gain_b1  = GainPrevRst;
      limit    = MaxDriveRst;
      sp_last = 0; ms_last = 0; integ_last = 0; drive_last = 0; drive_older = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_ERR_GAIN_NEW: gain_new = longint'(val);
        CFG_ERR_GAIN_OLD: gain_old = longint'(val);
        CFG_POLE_WEIGHT:  pole     = longint'(val);
        CFG_GAIN_NOW:     gain_b0  = longint'(val);
        CFG_GAIN_PREV:    gain_b1  = longint'(val);
        CFG_MAX_DRIVE:    limit    = longint'(val[MaxDriveW-1:0]);
        default: ;
      endcase
    endfunction

    // Add coef*v split into whole and fraction parts so nothing overflows
    function void add_term(longint coef, longint v);
      longint whole;
      longint part;
      whole = v >>> FracBitsDef;
      part  = v - (whole <<< FracBitsDef);
      hi_sum += coef * whole;
      lo_sum += coef * part;
    endfunction

    function logic signed [DriveW-1:0] next_drive(longint r, longint y, bit clr);
      longint integ, drive, bound, top, quot;
      top = (longint'(1) <<< (IntegW - 1)) - 1;
      if (clr) begin
        sp_last = 0; ms_last = 0; integ_last = 0; drive_last = 0; drive_older = 0;
      end
      // Integral increment, saturated to the state range
      integ = integ_last + gain_new * (r - y) - gain_old * (sp_last - ms_last);
      if (integ > top) integ = top;
      if (integ < -top - 1) integ = -top - 1;
      // Drive, exact sum floored to the fraction grid
      hi_sum = 0;
      lo_sum = 0;
      add_term((longint'(1) <<< FracBitsDef) + pole, drive_last);
      add_term(-pole, drive_older);
      add_term(gain_b0, integ);
      add_term(-gain_b1, integ_last);
      drive = hi_sum + (lo_sum >>> FracBitsDef);
      bound = limit <<< FracBitsDef;
      if (drive > bound) drive = bound;
      if (drive < -bound) drive = -bound;
      // Shift history
      sp_last = r;
      ms_last = y;
      integ_last = integ;
      drive_older = drive_last;
      drive_last = drive;
      quot = drive / (longint'(1) <<< FracBitsDef);
      return quot[DriveW-1:0];
    endfunction

    function void note_beat(logic signed [IncW-1:0] r, logic signed [IncW-1:0] y, logic clr);
      logic signed [DriveW-1:0] want;
      want = next_drive(longint'(r), longint'(y), clr);
      drive_due = {drive_due, want};
    endfunction

    function void check_beat(logic signed [DriveW-1:0] got);
      logic signed [DriveW-1:0] want;
      if (drive_due.size() == 0) begin
        $error("drive_value: no pending item, actual %0d", got);
        mismatches++;
      end else begin
        want = drive_due.pop_front();
        checked++;
        if (want !== got) begin
          $error("drive_value: expected %0d, actual %0d", want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [IncW-1:0] setpoint_increment_i = '0;
  logic signed [IncW-1:0] measured_increment_i = '0;
  logic clear_history_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [DriveW-1:0] drive_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  drive_tracker board;
  int gap_pct = 15;
  int stall_pct = 15;
  int items_sent = 0;
  int reg_writes = 0;
  longint cycle_count = 0;

  incremental_pd_i_position_regulator uut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .setpoint_increment_i (setpoint_increment_i),
    .measured_increment_i (measured_increment_i),
    .clear_history_i      (clear_history_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .drive_value_o        (drive_value_o),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_ready_o          (cfg_ready_o),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Check each drive beat, then pick the stall for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      board.check_beat(drive_value_o);
    end
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  // Hang guard
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    board.set_reg(idx, val);
    reg_writes++;
    @(posedge clk_i);
  endtask

  task automatic write_all(input int g_new, input int g_old, input int a, input int b0,
                           input int b1, input int lim);
    write_reg(CFG_ERR_GAIN_NEW, CfgDataW'(g_new));
    write_reg(CFG_ERR_GAIN_OLD, CfgDataW'(g_old));
    write_reg(CFG_POLE_WEIGHT,  CfgDataW'(a));
    write_reg(CFG_GAIN_NOW,     CfgDataW'(b0));
    write_reg(CFG_GAIN_PREV,    CfgDataW'(b1));
    write_reg(CFG_MAX_DRIVE,    CfgDataW'(lim));
  endtask

  // Offer one tick, with random idle cycles ahead of it
  task automatic send_item(input int r, input int y, input bit clr);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    setpoint_increment_i <= IncW'(r);
    measured_increment_i <= IncW'(y);
    clear_history_i <= clr;
    do @(posedge clk_i); while (in_stall_o);
    board.note_beat(setpoint_increment_i, measured_increment_i, clear_history_i);
    items_sent++;
  endtask

  // Mostly servo-like tracking, some full-range noise and edge values
  task automatic send_random(input int count);
    int kind, base, r, y;
    int edges[5];
    edges = '{-32768, -1, 0, 1, 32767};
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        base = int'($urandom_range(0, 4000)) - 2000;
        r = base;
        y = base + int'($urandom_range(0, 100)) - 50;
      end else if (kind < 85) begin
        r = int'(IncW'($urandom));
        y = int'(IncW'($urandom));
        r = (r > 32767) ? r - 65536 : r;
        y = (y > 32767) ? y - 65536 : y;
      end else begin
        r = edges[$urandom_range(0, 4)];
        y = edges[$urandom_range(0, 4)];
      end
      send_item(r, y, $urandom_range(0, 99) < 3);
    end
  endtask

  // Wait until every drive beat is back and the block has gone quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.drive_due.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);
  endtask

  initial begin
    int k;
    board = new();
    #1 rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks on reset gains: extremes, clamps, clears, truncation
    send_item(0, 0, 1'b0);
    repeat (5) send_item(32767, -32768, 1'b0);
    repeat (5) send_item(-32768, 32767, 1'b0);
    send_item(0, 0, 1'b1);
    send_item(-1, 1, 1'b0);
    send_item(1, -1, 1'b0);
    send_item(0, -1, 1'b0);
    send_item(0, 0, 1'b0);
    send_item(-32768, -32768, 1'b0);
    send_item(32767, 32767, 1'b0);
    send_item(100, 99, 1'b1);
    send_item(-7, 3, 1'b0);
    send_item(12345, -23456, 1'b0);
    send_item(-32768, 32767, 1'b1);
    drain();

    // Writes past the register map must not disturb anything
    write_reg(CfgIdxSpareA, CfgDataW'($urandom));
    write_reg(CfgIdxSpareB, CfgDataW'($urandom));
    gap_pct = 0;
    stall_pct = 0;
    send_random(150);
    gap_pct = 15;
    stall_pct = 15;
    send_random(150);
    drain();

    // Every coefficient and the clamp at the top
    write_all(CoefMax, CoefMax, CoefMax, CoefMax, CoefMax, DriveCap);
    send_random(200);
    drain();

    // All zero: drive is held at zero
    write_all(0, 0, 0, 0, 0, 0);
    send_random(80);
    drain();

    // Random gains, wide and narrow clamps, clamp data with spare high bits
    for (k = 0; k < 3; k++) begin
      write_all($urandom_range(0, CoefMax), $urandom_range(0, CoefMax),
                $urandom_range(0, CoefMax), $urandom_range(0, CoefMax),
                $urandom_range(0, CoefMax),
                (k == 1) ? $urandom_range(0, 40) : $urandom_range(0, CoefMax));
      send_random(120);
      drain();
    end

    // Push the integral hard in both directions at full speed
    write_all(CoefMax, 0, $urandom_range(0, CoefMax), $urandom_range(0, CoefMax),
              $urandom_range(0, CoefMax), DriveCap);
    gap_pct = 0;
    stall_pct = 0;
    send_item(32767, -32768, 1'b1);
    repeat (WindupLen) send_item(32767, -32768, 1'b0);
    send_item(-32768, 32767, 1'b1);
    repeat (WindupLen) send_item(-32768, 32767, 1'b0);
    gap_pct = 15;
    stall_pct = 15;
    drain();

    // Back to the power-on gains
    write_all(ErrGainNewRst, ErrGainOldRst, PoleWeightRst, GainNowRst, GainPrevRst,
              MaxDriveRst);
    send_random(150);
    drain();

    $display("Covered %0d ticks and %0d drive beats over %0d register writes.",
             items_sent, board.checked, reg_writes);
    $display("Settings: power-on, all-max, all-zero, random, full-scale error both ways.");
    if (board.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ipdr_pkg.sv
hdl/incremental_pd_i_position_regulator.sv
bench/incremental_pd_i_position_regulator_test.sv
